### rtl/pst_pkg.sv
`default_nettype none
package pst_pkg;

	// opcodes
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_END    = 2'd1;
	localparam logic [1:0] OP_ENTER  = 2'd2;
	localparam logic [1:0] OP_RESUME = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_NO_TASK   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slot;
		logic [15:0] pid;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_out;
		logic [15:0] new_id;
		logic [7:0]  current_slot;
		logic        current_valid;
	} result_t;

endpackage
`default_nettype wire

### rtl/pst_ram.sv
`default_nettype none
module pst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/process_slot_table_scheduler.sv
// Task slot table with round-robin resume; one command in flight at a time, the next
// beat taken at the edge that ends the done cycle. Latency is set by the scan over
// slots, one slot per cycle (valid bitmap for create and resume, read port of the id
// RAM for enter); an enter with id zero skips the scan and answers from idle.
// Reset (arst_n low) empties the table at once via the valid bitmap; ids restart at 1.
`default_nettype none
module process_slot_table_scheduler #(
	parameter int SLOTS   = 256,
	parameter int ID_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire pst_pkg::cmd_t   cmd,
	output logic                 busy,
	output logic                 done,
	output pst_pkg::result_t     result
);

	localparam int SB = $clog2(SLOTS);
	localparam int CW = (ID_BITS > 16) ? ID_BITS : 16;
	localparam logic [SB-1:0] LAST = SB'(SLOTS - 1);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CREATE = 2'd1;
	localparam logic [1:0] S_RESUME = 2'd2;
	localparam logic [1:0] S_ENTER  = 2'd3;

	logic [1:0]         state_q;
	logic [SLOTS-1:0]   valid_q;      // slot occupied; a clear bit reads as id zero
	logic [ID_BITS-1:0] next_id_q;
	logic [SB-1:0]      cursor_q;
	logic [SB-1:0]      run_slot_q;
	logic               run_valid_q;
	logic               swap_q;

	logic [SB-1:0]      scan_q;       // slot under test for create / resume
	logic [SB:0]        left_q;       // slots still to visit on resume
	logic [SB:0]        ra_q;         // id RAM read address for enter
	logic [15:0]        pid_q;
	logic               rd_vld_s1;
	logic [SB-1:0]      rd_idx_s1;

	logic               done_q;
	logic [1:0]         status_q;
	logic [SB-1:0]      slot_out_q;
	logic [15:0]        new_id_q;

	logic [ID_BITS-1:0] rd_data;
	logic               issue;
	logic               match;
	logic [SB-1:0]      scan_nxt;
	logic [SB-1:0]      cur_nxt;
	logic [ID_BITS-1:0] id_inc;
	logic [ID_BITS-1:0] id_nxt;
	logic [CW-1:0]      id_ext;
	logic               slot_in_range;
	logic [SB-1:0]      end_idx;
	logic               alloc_we;

	// --- combinational helpers ---
	assign scan_nxt      = (scan_q == LAST) ? '0 : scan_q + 1'b1;
	assign cur_nxt       = (cursor_q == LAST) ? '0 : cursor_q + 1'b1;
	assign id_inc        = next_id_q + 1'b1;
	assign id_nxt        = (id_inc == '0) ? ID_BITS'(1) : id_inc;   // id zero is skipped
	assign id_ext        = CW'(next_id_q);
	assign slot_in_range = ({1'b0, cmd.slot} < 9'(SLOTS));
	assign end_idx       = cmd.slot[SB-1:0];

	// enter streams addresses into the RAM; compare lands in the cycle after the read is issued
	assign issue    = (state_q == S_ENTER) && (ra_q < (SB+1)'(SLOTS));
	assign match    = rd_vld_s1 && valid_q[rd_idx_s1] && (CW'(rd_data) == CW'(pid_q));
	assign alloc_we = (state_q == S_CREATE) && !valid_q[scan_q];

	// Id store. Only written by create, only read by enter, so the two never overlap
	// and no forwarding is needed; stale ids of ended slots are masked by valid_q.
	pst_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (SLOTS)
	) u_id_ram (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (scan_q),
		.wdata (next_id_q),
		.re    (issue),
		.raddr (ra_q[SB-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			next_id_q   <= ID_BITS'(1);
			cursor_q    <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			swap_q      <= 1'b0;
			scan_q      <= '0;
			left_q      <= '0;
			ra_q        <= '0;
			pid_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			done_q      <= 1'b0;
			status_q    <= pst_pkg::STAT_OK;
			slot_out_q  <= '0;
			new_id_q    <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			rd_idx_s1 <= ra_q[SB-1:0];
			if (issue) begin
				ra_q <= ra_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						slot_out_q <= '0;
						new_id_q   <= '0;
						pid_q      <= cmd.pid;
						case (cmd.op)
							pst_pkg::OP_CREATE: begin
								scan_q  <= '0;
								state_q <= S_CREATE;
							end
							pst_pkg::OP_END: begin
								// free the slot; ending the running task arms a swap
								if (slot_in_range) begin
									valid_q[end_idx] <= 1'b0;
									if (run_valid_q && run_slot_q == end_idx) begin
										swap_q <= 1'b1;
									end
								end
								scan_q  <= cur_nxt;
								left_q  <= (SB+1)'(SLOTS);
								state_q <= S_RESUME;
							end
							pst_pkg::OP_ENTER: begin
								if (cmd.pid == '0) begin
									status_q <= pst_pkg::STAT_NOT_FOUND;
									done_q   <= 1'b1;
								end else begin
									ra_q    <= '0;
									state_q <= S_ENTER;
								end
							end
							default: begin
								scan_q  <= cur_nxt;
								left_q  <= (SB+1)'(SLOTS);
								state_q <= S_RESUME;
							end
						endcase
					end
				end
				S_CREATE: begin
					// lowest free slot wins
					if (!valid_q[scan_q]) begin
						valid_q[scan_q] <= 1'b1;
						cursor_q        <= scan_q;
						slot_out_q      <= scan_q;
						new_id_q        <= id_ext[15:0];
						next_id_q       <= id_nxt;
						status_q        <= pst_pkg::STAT_OK;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else if (scan_q == LAST) begin
						status_q <= pst_pkg::STAT_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						scan_q <= scan_nxt;
					end
				end
				S_RESUME: begin
					if (!swap_q) begin
						status_q <= run_valid_q ? pst_pkg::STAT_OK : pst_pkg::STAT_NO_TASK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (valid_q[scan_q]) begin
						// next occupied slot after the cursor
						cursor_q    <= scan_q;
						run_slot_q  <= scan_q;
						run_valid_q <= 1'b1;
						swap_q      <= 1'b0;
						status_q    <= pst_pkg::STAT_OK;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (left_q == (SB+1)'(1)) begin
						// table empty: swap stays armed
						run_valid_q <= 1'b0;
						status_q    <= pst_pkg::STAT_NO_TASK;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						scan_q <= scan_nxt;
						left_q <= left_q - 1'b1;
					end
				end
				S_ENTER: begin
					if (match) begin
						swap_q      <= 1'b0;
						run_slot_q  <= rd_idx_s1;
						run_valid_q <= 1'b1;
						slot_out_q  <= rd_idx_s1;
						status_q    <= pst_pkg::STAT_OK;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (rd_vld_s1 && rd_idx_s1 == LAST) begin
						status_q <= pst_pkg::STAT_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// --- outputs ---
	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// running-task fields follow the registers, which settle on the same edge as done
	assign result.status        = status_q;
	assign result.slot_out      = 8'(slot_out_q);
	assign result.new_id        = new_id_q;
	assign result.current_slot  = 8'(run_slot_q);
	assign result.current_valid = run_valid_q;

	// --- checks ---
	// a result beat is only ever shown with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	// with no swap armed, the running task always sits in an occupied slot
	a_run_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(run_valid_q && !swap_q) |-> valid_q[run_slot_q])
		else $error("running slot is empty");

	// table full is reported only when every slot is taken
	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == pst_pkg::STAT_FULL) |-> (&valid_q))
		else $error("full reported with a free slot");

	// id counter never hands out zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id is zero");

endmodule
`default_nettype wire
